>>> hdl/mark_sweep_slot_arena_macros.svh
`ifndef MARK_SWEEP_SLOT_ARENA_MACROS_SVH
`define MARK_SWEEP_SLOT_ARENA_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define MSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Invariant checked on every rising edge outside reset.
`define MSA_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  `MSA_ASSERT_IMP(lbl, clk, rst_n, 1'b1, cond, msg)

`endif

>>> hdl/msa_pkg.sv
package msa_pkg;

  localparam int SLOTS       = 256;
  localparam int HANDLE_BITS = 32;

  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int CNT_W   = SLOT_W + 1;
  localparam int VAL_W   = (HANDLE_BITS > CNT_W) ? HANDLE_BITS : CNT_W;
  localparam int ENTRY_W = VAL_W + 2;

  localparam int FUNC_PORT_W   = 2;
  localparam int SLOT_PORT_W   = 8;
  localparam int PAY_PORT_W    = 32;
  localparam int COUNT_PORT_W  = 9;
  localparam int STATUS_PORT_W = 2;

  typedef enum logic [FUNC_PORT_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_MARK   = 2'd1,
    FUNC_SWEEP  = 2'd2,
    FUNC_READ   = 2'd3
  } func_e;

  typedef enum logic [STATUS_PORT_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_BAD  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP
  } state_e;

  // A free entry keeps the next free slot in val; an occupied one keeps the handle.
  typedef struct packed {
    logic             keep;
    logic             used;
    logic [VAL_W-1:0] val;
  } entry_t;

endpackage

>>> hdl/mark_sweep_slot_arena.sv
// Insert, mark and read first read the slot memory, then insert and mark update it.
// Their result word is strobed on done_o in the cycle after that, when start may already
// be taken again, so a new request can be accepted while the last result word is shown.
// A sweep walks every slot below high water, reading each and writing back those it frees or unmarks.
// Reset clears high water, occupancy and free head at once; the slot memory needs no clearing.
`include "mark_sweep_slot_arena_macros.svh"

module mark_sweep_slot_arena (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [msa_pkg::FUNC_PORT_W-1:0]        func_i,
  input  logic [msa_pkg::SLOT_PORT_W-1:0]        slot_i,
  input  logic [msa_pkg::PAY_PORT_W-1:0]         payload_i,
  output logic                                   done_o,
  output logic [msa_pkg::SLOT_PORT_W-1:0]        slot_out_o,
  output logic [msa_pkg::PAY_PORT_W-1:0]         payload_out_o,
  output logic [msa_pkg::COUNT_PORT_W-1:0]       freed_count_o,
  output logic [msa_pkg::COUNT_PORT_W-1:0]       live_count_o,
  output logic [msa_pkg::STATUS_PORT_W-1:0]      status_o
);

  msa_pkg::state_e                      state_q, state_d;
  msa_pkg::func_e                       func_q, func_d;
  logic [msa_pkg::SLOT_PORT_W-1:0]      slot_q, slot_d;
  logic [msa_pkg::PAY_PORT_W-1:0]       payload_q, payload_d;
  logic [msa_pkg::CNT_W-1:0]            free_head_q, free_head_d;
  logic [msa_pkg::CNT_W-1:0]            high_water_q, high_water_d;
  logic [msa_pkg::CNT_W-1:0]            occupied_q, occupied_d;
  logic [msa_pkg::CNT_W-1:0]            idx_q, idx_d;
  logic [msa_pkg::CNT_W-1:0]            freed_q, freed_d;

  logic                                 done_q, done_d;
  logic [msa_pkg::SLOT_PORT_W-1:0]      slot_out_q, slot_out_d;
  logic [msa_pkg::PAY_PORT_W-1:0]       pay_out_q, pay_out_d;
  logic [msa_pkg::COUNT_PORT_W-1:0]     freed_out_q, freed_out_d;
  logic [msa_pkg::COUNT_PORT_W-1:0]     live_out_q, live_out_d;
  msa_pkg::status_e                     status_q, status_d;

  logic                                 accept;
  logic                                 mem_we;
  logic [msa_pkg::SLOT_W-1:0]           mem_waddr;
  logic [msa_pkg::SLOT_W-1:0]           mem_raddr;
  logic [msa_pkg::ENTRY_W-1:0]          mem_rdata;
  msa_pkg::entry_t                      rd_entry;
  msa_pkg::entry_t                      wr_entry;
  logic [msa_pkg::HANDLE_BITS-1:0]      handle;
  logic                                 list_nonempty;
  logic                                 slot_live;
  logic                                 walk_active;

  assign busy          = (state_q != msa_pkg::ST_IDLE);
  assign accept        = start && !busy;
  assign rd_entry      = msa_pkg::entry_t'(mem_rdata);
  assign handle        = msa_pkg::HANDLE_BITS'(payload_q);
  assign list_nonempty = (free_head_q < high_water_q);
  assign slot_live     = (msa_pkg::CNT_W'(slot_q) < high_water_q) && rd_entry.used;
  assign walk_active   = (idx_q < high_water_q);

  msa_ram #(
    .DEPTH (msa_pkg::SLOTS),
    .WIDTH (msa_pkg::ENTRY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (wr_entry),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      msa_pkg::ST_IDLE: begin
        if (accept) begin
          if (msa_pkg::func_e'(func_i) == msa_pkg::FUNC_SWEEP) begin
            state_d = msa_pkg::ST_SWEEP;
          end else begin
            state_d = msa_pkg::ST_EXEC;
          end
        end
      end
      msa_pkg::ST_EXEC: begin
        state_d = msa_pkg::ST_IDLE;
      end
      msa_pkg::ST_SWEEP: begin
        if (!walk_active) begin
          state_d = msa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = msa_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    func_d       = func_q;
    slot_d       = slot_q;
    payload_d    = payload_q;
    free_head_d  = free_head_q;
    high_water_d = high_water_q;
    occupied_d   = occupied_q;
    idx_d        = idx_q;
    freed_d      = freed_q;
    done_d       = 1'b0;
    slot_out_d   = slot_out_q;
    pay_out_d    = pay_out_q;
    freed_out_d  = freed_out_q;
    live_out_d   = live_out_q;
    status_d     = status_q;
    mem_we       = 1'b0;
    mem_waddr    = msa_pkg::SLOT_W'(slot_q);
    mem_raddr    = msa_pkg::SLOT_W'(idx_q + 1'b1);
    wr_entry     = rd_entry;

    case (state_q)
      msa_pkg::ST_IDLE: begin
        case (msa_pkg::func_e'(func_i))
          msa_pkg::FUNC_INSERT: mem_raddr = msa_pkg::SLOT_W'(free_head_q);
          msa_pkg::FUNC_SWEEP:  mem_raddr = '0;
          default:              mem_raddr = msa_pkg::SLOT_W'(slot_i);
        endcase
        if (accept) begin
          func_d    = msa_pkg::func_e'(func_i);
          slot_d    = slot_i;
          payload_d = payload_i;
          idx_d     = '0;
          freed_d   = '0;
        end
      end

      msa_pkg::ST_EXEC: begin
        done_d      = 1'b1;
        slot_out_d  = slot_q;
        pay_out_d   = '0;
        freed_out_d = '0;
        status_d    = msa_pkg::STATUS_OK;
        wr_entry    = '{keep: 1'b0, used: 1'b1, val: msa_pkg::VAL_W'(handle)};
        case (func_q)
          msa_pkg::FUNC_INSERT: begin
            if (list_nonempty) begin
              mem_we      = 1'b1;
              mem_waddr   = msa_pkg::SLOT_W'(free_head_q);
              free_head_d = rd_entry.val[msa_pkg::CNT_W-1:0];
              occupied_d  = occupied_q + 1'b1;
              slot_out_d  = msa_pkg::SLOT_PORT_W'(free_head_q);
            end else if (high_water_q < msa_pkg::CNT_W'(msa_pkg::SLOTS)) begin
              mem_we       = 1'b1;
              mem_waddr    = msa_pkg::SLOT_W'(high_water_q);
              high_water_d = high_water_q + 1'b1;
              free_head_d  = high_water_q + 1'b1;
              occupied_d   = occupied_q + 1'b1;
              slot_out_d   = msa_pkg::SLOT_PORT_W'(high_water_q);
            end else begin
              status_d   = msa_pkg::STATUS_FULL;
              slot_out_d = '0;
            end
          end
          msa_pkg::FUNC_MARK: begin
            if (slot_live) begin
              mem_we   = 1'b1;
              wr_entry = '{keep: 1'b1, used: 1'b1, val: rd_entry.val};
            end else begin
              status_d = msa_pkg::STATUS_BAD;
            end
          end
          msa_pkg::FUNC_READ: begin
            if (slot_live) begin
              pay_out_d = msa_pkg::PAY_PORT_W'(rd_entry.val);
            end else begin
              status_d = msa_pkg::STATUS_BAD;
            end
          end
          default: begin
            status_d = msa_pkg::STATUS_OK;
          end
        endcase
        live_out_d = msa_pkg::COUNT_PORT_W'(occupied_d);
      end

      msa_pkg::ST_SWEEP: begin
        if (walk_active) begin
          mem_waddr = msa_pkg::SLOT_W'(idx_q);
          idx_d     = idx_q + 1'b1;
          if (rd_entry.used && !rd_entry.keep) begin
            mem_we      = 1'b1;
            wr_entry    = '{keep: 1'b0, used: 1'b0, val: msa_pkg::VAL_W'(free_head_q)};
            free_head_d = idx_q;
            freed_d     = freed_q + 1'b1;
            if (occupied_q != '0) begin
              occupied_d = occupied_q - 1'b1;
            end
          end else if (rd_entry.keep) begin
            mem_we   = 1'b1;
            wr_entry = '{keep: 1'b0, used: rd_entry.used, val: rd_entry.val};
          end
        end else begin
          done_d      = 1'b1;
          slot_out_d  = slot_q;
          pay_out_d   = '0;
          freed_out_d = msa_pkg::COUNT_PORT_W'(freed_q);
          live_out_d  = msa_pkg::COUNT_PORT_W'(occupied_q);
          status_d    = msa_pkg::STATUS_OK;
        end
      end

      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= msa_pkg::ST_IDLE;
      free_head_q  <= '0;
      high_water_q <= '0;
      occupied_q   <= '0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      free_head_q  <= free_head_d;
      high_water_q <= high_water_d;
      occupied_q   <= occupied_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q      <= func_d;
    slot_q      <= slot_d;
    payload_q   <= payload_d;
    idx_q       <= idx_d;
    freed_q     <= freed_d;
    slot_out_q  <= slot_out_d;
    pay_out_q   <= pay_out_d;
    freed_out_q <= freed_out_d;
    live_out_q  <= live_out_d;
    status_q    <= status_d;
  end

  assign done_o        = done_q;
  assign slot_out_o    = slot_out_q;
  assign payload_out_o = pay_out_q;
  assign freed_count_o = freed_out_q;
  assign live_count_o  = live_out_q;
  assign status_o      = status_q;

  `MSA_ASSERT_ALWAYS(a_head_within_hw, clk_i, rst_ni, free_head_q <= high_water_q,
    "Free-list head is above the high-water mark.")
  `MSA_ASSERT_ALWAYS(a_occupied_within_hw, clk_i, rst_ni, occupied_q <= high_water_q,
    "More slots are occupied than lie below the high-water mark.")
  `MSA_ASSERT_IMP(a_result_on_release, clk_i, rst_ni, $fell(busy), done_o,
    "The block went idle without giving a result word.")
  `MSA_ASSERT_IMP(a_full_only_at_top, clk_i, rst_ni,
    done_o && (status_o == msa_pkg::STATUS_FULL),
    high_water_q == msa_pkg::CNT_W'(msa_pkg::SLOTS),
    "Arena reported full while the high-water mark is below the top.")

endmodule

>>> hdl/msa_ram.sv
module msa_ram #(
  parameter  int DEPTH = 256,
  parameter  int WIDTH = 34,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
